// ===== design/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// shared types and codes for the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int FUNC_W   = 3;
   localparam int POS_W    = 8;
   localparam int FIELD_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // request beat layout
   localparam int REQ_FUNC_LSB = 0;
   localparam int REQ_POS_LSB  = REQ_FUNC_LSB + FUNC_W;
   localparam int REQ_DATA_LSB = REQ_POS_LSB + POS_W;
   localparam int REQ_BITS     = REQ_DATA_LSB + FIELD_W;
   localparam int REQ_TDATA_W  = ((REQ_BITS + 7) / 8) * 8;

   // response beat layout
   localparam int RSP_STATUS_LSB = 0;
   localparam int RSP_READ_LSB   = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_COUNT_LSB  = RSP_READ_LSB + FIELD_W;
   localparam int RSP_FIRST_LSB  = RSP_COUNT_LSB + COUNT_W;
   localparam int RSP_LAST_LSB   = RSP_FIRST_LSB + FIELD_W;
   localparam int RSP_BITS       = RSP_LAST_LSB + FIELD_W;
   localparam int RSP_TDATA_W    = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [FUNC_W-1:0] FUNC_APPEND   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DEL_LAST = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DEL_AT   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TAP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic ins;
      logic del;
      logic tap;
      logic rd_en;
      logic last_en;
   } cell_ctrl_type;

endpackage

// ===== design/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// one list slot: holds a word, shifts up or down with its neighbors
// ----------------------------------------------------------------------------
module ple_cell #(
   parameter int INDEX      = 0,
   parameter int IW         = 6,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  ple_pkg::cell_ctrl_type ctrl,
   input  logic [IW-1:0]         op_idx,
   input  logic [IW-1:0]         rd_idx,
   input  logic [IW-1:0]         last_idx,
   input  logic [DATA_WIDTH-1:0] word,
   input  logic [DATA_WIDTH-1:0] prev_data,
   input  logic [DATA_WIDTH-1:0] next_data,
   output logic [DATA_WIDTH-1:0] data,
   output logic [DATA_WIDTH-1:0] rd_tap,
   output logic [DATA_WIDTH-1:0] last_tap
);

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic [DATA_WIDTH-1:0] rd_tap_ff, rd_tap_in;
   logic [DATA_WIDTH-1:0] last_tap_ff, last_tap_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (MY_IDX == op_idx) begin
            data_in = word;
         end else if (MY_IDX > op_idx) begin
            data_in = prev_data;
         end
      end else if (ctrl.del) begin
         if (MY_IDX >= op_idx) begin
            data_in = next_data;
         end
      end
   end

   always_comb begin
      rd_tap_in   = rd_tap_ff;
      last_tap_in = last_tap_ff;
      if (ctrl.tap) begin
         rd_tap_in   = (ctrl.rd_en && MY_IDX == rd_idx) ? data_ff : '0;
         last_tap_in = (ctrl.last_en && MY_IDX == last_idx) ? data_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      rd_tap_ff   <= rd_tap_in;
      last_tap_ff <= last_tap_in;
   end

   assign data     = data_ff;
   assign rd_tap   = rd_tap_ff;
   assign last_tap = last_tap_ff;

endmodule

// ===== design/ple_ctrl.sv =====
// ----------------------------------------------------------------------------
// ple_ctrl
// sequencer: decodes a request, drives the cell row, keeps the count and
// holds the response beat
// ----------------------------------------------------------------------------
module ple_ctrl #(
   parameter int ENTRIES    = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ple_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ple_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output ple_pkg::cell_ctrl_type           cell_ctrl,
   output logic [$clog2(ENTRIES)-1:0]       op_idx,
   output logic [$clog2(ENTRIES)-1:0]       rd_idx,
   output logic [$clog2(ENTRIES)-1:0]       last_idx,
   output logic [DATA_WIDTH-1:0]            word,
   input  logic [DATA_WIDTH-1:0]            first_word,
   input  logic [DATA_WIDTH-1:0]            rd_word,
   input  logic [DATA_WIDTH-1:0]            last_word
);

   localparam int IW   = $clog2(ENTRIES);
   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int CMPW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;
   localparam int FW   = ple_pkg::FIELD_W;
   localparam int NW   = ple_pkg::COUNT_W;
   localparam int SW   = ple_pkg::STATUS_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

   ple_pkg::state_type state_ff, state_in;

   logic [ple_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [ple_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [DATA_WIDTH-1:0]      word_ff, word_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [SW-1:0]              status_ff, status_in;
   logic                       rd_en_ff, rd_en_in;
   logic [IW-1:0]              rd_idx_ff, rd_idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ple_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic          req_accept;
   logic          rsp_load;
   logic          pos_ge;
   logic          full;
   logic          empty;
   logic          do_ins;
   logic          do_del;
   logic          rd_ok;
   logic [SW-1:0] exec_status;
   logic [IW-1:0] exec_idx;
   logic [FW-1:0] first_field;
   logic [FW-1:0] last_field;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == ple_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   // operation decode against the current count
   always_comb begin
      pos_ge      = CMPW'(pos_ff) >= CMPW'(count_ff);
      full        = count_ff == FULL_COUNT;
      empty       = count_ff == '0;
      do_ins      = 1'b0;
      do_del      = 1'b0;
      rd_ok       = 1'b0;
      exec_status = ple_pkg::STATUS_OK;
      exec_idx    = IW'(pos_ff);
      unique case (func_ff)
         ple_pkg::FUNC_APPEND, ple_pkg::FUNC_INSERT: begin
            if (full) begin
               exec_status = ple_pkg::STATUS_FULL;
            end else begin
               do_ins = 1'b1;
               if (func_ff == ple_pkg::FUNC_APPEND || pos_ge) begin
                  exec_idx = IW'(count_ff);
               end
            end
         end
         ple_pkg::FUNC_DEL_LAST, ple_pkg::FUNC_DEL_AT: begin
            if (empty) begin
               exec_status = ple_pkg::STATUS_EMPTY;
            end else begin
               do_del = 1'b1;
               if (func_ff == ple_pkg::FUNC_DEL_LAST || pos_ge) begin
                  exec_idx = IW'(count_ff - CW'(1));
               end
            end
         end
         ple_pkg::FUNC_READ: begin
            if (pos_ge) begin
               exec_status = ple_pkg::STATUS_RANGE;
            end else begin
               rd_ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ple_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = ple_pkg::ST_EXEC;
            end
         end
         ple_pkg::ST_EXEC: state_in = ple_pkg::ST_TAP;
         ple_pkg::ST_TAP:  state_in = ple_pkg::ST_EMIT;
         ple_pkg::ST_EMIT: begin
            if (rsp_load) begin
               state_in = ple_pkg::ST_IDLE;
            end
         end
         default: state_in = ple_pkg::ST_IDLE;
      endcase
   end

   // outputs to the port and the cell row
   always_comb begin
      req_tready        = state_ff == ple_pkg::ST_IDLE;
      cell_ctrl.ins     = (state_ff == ple_pkg::ST_EXEC) && do_ins;
      cell_ctrl.del     = (state_ff == ple_pkg::ST_EXEC) && do_del;
      cell_ctrl.tap     = state_ff == ple_pkg::ST_TAP;
      cell_ctrl.rd_en   = rd_en_ff;
      cell_ctrl.last_en = count_ff != '0;
      op_idx            = exec_idx;
      rd_idx            = rd_idx_ff;
      last_idx          = IW'(count_ff - CW'(1));
      word              = word_ff;
   end

   // request capture, count and response register
   always_comb begin
      func_in      = func_ff;
      pos_in       = pos_ff;
      word_in      = word_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      rd_en_in     = rd_en_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      first_field  = (count_ff != '0) ? FW'(first_word) : '0;
      last_field   = FW'(last_word);
      if (req_accept) begin
         func_in = req_tdata[ple_pkg::REQ_FUNC_LSB +: ple_pkg::FUNC_W];
         pos_in  = req_tdata[ple_pkg::REQ_POS_LSB +: ple_pkg::POS_W];
         word_in = DATA_WIDTH'(req_tdata[ple_pkg::REQ_DATA_LSB +: FW]);
      end
      if (state_ff == ple_pkg::ST_EXEC) begin
         if (do_ins) begin
            count_in = count_ff + CW'(1);
         end else if (do_del) begin
            count_in = count_ff - CW'(1);
         end
         status_in = exec_status;
         rd_en_in  = rd_ok;
         rd_idx_in = IW'(pos_ff);
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[ple_pkg::RSP_STATUS_LSB +: SW] = status_ff;
         rsp_data_in[ple_pkg::RSP_READ_LSB +: FW]   = FW'(rd_word);
         rsp_data_in[ple_pkg::RSP_COUNT_LSB +: NW]  = NW'(count_ff);
         rsp_data_in[ple_pkg::RSP_FIRST_LSB +: FW]  = first_field;
         rsp_data_in[ple_pkg::RSP_LAST_LSB +: FW]   = last_field;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ple_pkg::ST_IDLE;
         count_ff     <= '0;
         rd_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_en_ff     <= rd_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      pos_ff      <= pos_in;
      word_ff     <= word_in;
      status_ff   <= status_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("list count above capacity");

   a_exec_to_tap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ple_pkg::ST_EXEC |=> state_ff == ple_pkg::ST_TAP)
      else $error("exec step not followed by tap step");

   a_count_only_in_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff != ple_pkg::ST_EXEC |=> $stable(count_ff))
      else $error("count changed outside exec step");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_load && status_ff == ple_pkg::STATUS_EMPTY |-> count_ff == '0)
      else $error("empty status with stored words");

endmodule

// ===== design/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// bounded ordered list of words held in a row of shifting cells
//
// channel  dir  tdata fields, lowest bit up
// req      in   func[2:0] position[10:3] data_value[42:11] (48 bits)
// rsp      out  status[1:0] read_value[33:2] element_count[40:34]
//               first_value[72:41] last_value[104:73] (112 bits)
//
// each beat passes through capture, cell shift, tap latch and response load
// a new request beat is taken while the previous response still waits
// rsp stall holds the sequencer in its response step until the slot frees
// reset clears the count and handshake state; cell words are left as they are
// ----------------------------------------------------------------------------
module positional_list_engine #(
   parameter int ENTRIES    = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ple_pkg::REQ_TDATA_W-1:0] req_tdata,  // func, position, data_value
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ple_pkg::RSP_TDATA_W-1:0] rsp_tdata   // status, read_value,
                                                       // element_count, first, last
);

   localparam int IW = $clog2(ENTRIES);

   ple_pkg::cell_ctrl_type cell_ctrl;
   logic [IW-1:0]          op_idx;
   logic [IW-1:0]          rd_idx;
   logic [IW-1:0]          last_idx;
   logic [DATA_WIDTH-1:0]  word;
   logic [DATA_WIDTH-1:0]  cell_data [ENTRIES];
   logic [DATA_WIDTH-1:0]  rd_tap    [ENTRIES];
   logic [DATA_WIDTH-1:0]  last_tap  [ENTRIES];
   logic [DATA_WIDTH-1:0]  rd_word;
   logic [DATA_WIDTH-1:0]  last_word;
   logic [ENTRIES-1:0]     rd_col;
   logic [ENTRIES-1:0]     last_col;

   ple_ctrl #(
      .ENTRIES    (ENTRIES),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cell_ctrl  (cell_ctrl),
      .op_idx     (op_idx),
      .rd_idx     (rd_idx),
      .last_idx   (last_idx),
      .word       (word),
      .first_word (cell_data[0]),
      .rd_word    (rd_word),
      .last_word  (last_word)
   );

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_data;
      logic [DATA_WIDTH-1:0] next_data;

      if (i == 0) begin : g_head
         assign prev_data = word;
      end else begin : g_body
         assign prev_data = cell_data[i-1];
      end

      if (i == ENTRIES - 1) begin : g_tail
         assign next_data = cell_data[i];
      end else begin : g_inner
         assign next_data = cell_data[i+1];
      end

      ple_cell #(
         .INDEX      (i),
         .IW         (IW),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .op_idx    (op_idx),
         .rd_idx    (rd_idx),
         .last_idx  (last_idx),
         .word      (word),
         .prev_data (prev_data),
         .next_data (next_data),
         .data      (cell_data[i]),
         .rd_tap    (rd_tap[i]),
         .last_tap  (last_tap[i])
      );
   end

   // registered taps are zero except at the selected cell
   always_comb begin
      for (int b = 0; b < DATA_WIDTH; b++) begin
         for (int i = 0; i < ENTRIES; i++) begin
            rd_col[i]   = rd_tap[i][b];
            last_col[i] = last_tap[i][b];
         end
         rd_word[b]   = |rd_col;
         last_word[b] = |last_col;
      end
   end

endmodule
